// ===== hdl/pidc_pkg.sv =====
// ----------------------------------------------------------------------------
// PID controller package
// Shared constants, register indexes and sequencer types for the clamped
// PID controller.
// ----------------------------------------------------------------------------
package pidc_pkg;

   localparam int SAMPLE_WIDTH_DEF = 16;
   localparam int FRAC_BITS_DEF    = 16;

   localparam int SUM_W      = 48;
   localparam int GAIN_W     = 32;
   localparam int STEP_W     = 31;
   localparam int DRIVE_W    = 32;
   localparam int MUL_W      = 32;
   localparam int CSR_DATA_W = 32;
   localparam int CSR_ADDR_W = 5;
   localparam int CSR_IDX_W  = 3;

   localparam logic [CSR_IDX_W-1:0] CSR_PROP_GAIN  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_INTEG_GAIN = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_DERIV_GAIN = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_TIME_STEP  = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_OUT_LOW    = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_OUT_HIGH   = 3'd5;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_INT_OPS,
      ST_INT_MUL,
      ST_INT_ADD,
      ST_OPS,
      ST_MUL,
      ST_ACC,
      ST_CLAMP,
      ST_DONE
   } pidc_state_type;

   typedef enum logic [1:0] {
      TERM_P,
      TERM_I,
      TERM_D
   } pidc_term_type;

endpackage

// ===== hdl/pidc_if.sv =====
// ----------------------------------------------------------------------------
// PID controller channels
// Valid/ready channels for sample transactions and drive transactions.
// ----------------------------------------------------------------------------
interface pidc_req_if import pidc_pkg::*; #(
   parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF
) ();
   logic                           valid;
   logic                           ready;
   logic signed [SAMPLE_WIDTH-1:0] target;
   logic signed [SAMPLE_WIDTH-1:0] measured;

   modport source (output valid, output target, output measured, input ready);
   modport sink (input valid, input target, input measured, output ready);
endinterface

interface pidc_rsp_if import pidc_pkg::*; ();
   logic                      valid;
   logic                      ready;
   logic signed [DRIVE_W-1:0] drive;

   modport source (output valid, output drive, input ready);
   modport sink (input valid, input drive, output ready);
endinterface

// ===== hdl/pid_controller_clamped.sv =====
// One sample is in flight at a time: a new sample is accepted only once the previous
// drive has been loaded. The restoring divider for the derivative sets the pace; the
// proportional and integral products run on the shared 32x32 multiplier while it iterates.
// Reset is synchronous: registers take their documented values, the integral
// and the previous error clear, and no transaction is pending.
// ----------------------------------------------------------------------------
// Clamped PID controller
// Positional PID with saturating integral, exact derivative division and a
// clamped Q16.16 drive output, built around one shared multiplier.
// ----------------------------------------------------------------------------
module pid_controller_clamped import pidc_pkg::*; #(
   parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF,
   parameter int FRAC_BITS    = FRAC_BITS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   pidc_req_if.sink              req_chan,
   pidc_rsp_if.source            rsp_chan,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

   localparam int ERR_W  = SAMPLE_WIDTH + 1;
   localparam int DIFF_W = SAMPLE_WIDTH + 2;
   localparam int DMAG_W = SAMPLE_WIDTH + 1;
   localparam int NUM_W  = DMAG_W + 2 * FRAC_BITS;
   localparam int A_W    = (NUM_W > SUM_W) ? NUM_W : SUM_W;
   localparam int NCH    = (A_W + MUL_W - 1) / MUL_W;
   localparam int CH_W   = (NCH > 1) ? $clog2(NCH) : 1;
   localparam int PROD_W = 2 * MUL_W;
   localparam int ACC_W  = A_W + MUL_W + FRAC_BITS + 3;
   localparam int SH_W   = $clog2(ACC_W);
   localparam int TOT_W  = ACC_W - FRAC_BITS;
   localparam int INC_W  = SUM_W + 1;
   localparam int SUMX_W = SUM_W + 2;

   localparam logic [PROD_W-1:0]        INC_CAP   = PROD_W'(1) << SUM_W;
   localparam logic signed [SUMX_W-1:0] SUMX_MAX  = {3'b000, {(SUM_W-1){1'b1}}};
   localparam logic signed [SUMX_W-1:0] SUMX_MIN  = {3'b111, {(SUM_W-1){1'b0}}};
   localparam logic [STEP_W-1:0]        STEP_ONE  = STEP_W'(64'd1 << FRAC_BITS);

   pidc_state_type state_ff, state_in;

   logic signed [GAIN_W-1:0] prop_gain_ff, integ_gain_ff, deriv_gain_ff;
   logic signed [GAIN_W-1:0] out_low_ff, out_high_ff;
   logic [STEP_W-1:0]        time_step_ff;

   logic signed [ERR_W-1:0]  err_ff, last_err_ff;
   logic [SAMPLE_WIDTH-1:0]  err_mag_ff;
   logic signed [SUM_W-1:0]  error_sum_ff;
   logic                     diff_neg_ff;
   logic [MUL_W-1:0]         opa_ff, opb_ff;
   logic [PROD_W-1:0]        mul_ff;
   logic                     neg_ff;
   pidc_term_type            term_ff;
   logic [CH_W-1:0]          chunk_ff;
   logic [ACC_W-1:0]         acc_ff;
   logic                     over_ff, under_ff;
   logic [DRIVE_W-1:0]       tot_lo_ff;
   logic signed [DRIVE_W-1:0] drive_ff;
   logic                     rsp_valid_ff;

   logic in_ready, div_start, int_ops, mul_en, int_upd, ops_en, acc_en;
   logic clamp_en, out_load;

   logic                     csr_wr;
   logic [CSR_IDX_W-1:0]     csr_idx;
   logic [STEP_W-1:0]        dt;
   logic signed [ERR_W-1:0]  err_in;
   logic [ERR_W-1:0]         err_abs;
   logic signed [DIFF_W-1:0] diff;
   logic [DIFF_W-1:0]        diff_abs;
   logic [NUM_W-1:0]         div_num;
   logic [NUM_W-1:0]         quot;
   logic                     div_busy;
   logic [INC_W-1:0]         inc;
   logic signed [SUMX_W-1:0] inc_x, sum_x;
   logic [SUM_W-1:0]         sum_abs;
   logic signed [GAIN_W-1:0] gain_sel;
   logic [GAIN_W-1:0]        gain_abs;
   logic [A_W-1:0]           a_sel;
   logic                     a_neg;
   logic [NCH*MUL_W-1:0]     a_ext;
   logic [SH_W-1:0]          shamt;
   logic [ACC_W-1:0]         addend;
   logic signed [TOT_W-1:0]  total;
   logic                     last_chunk;
   logic                     out_free;

   // Configuration registers.
   assign csr_wr     = csr_psel & csr_penable & csr_pwrite;
   assign csr_idx    = csr_paddr[CSR_ADDR_W-1:CSR_ADDR_W-CSR_IDX_W];
   assign csr_pready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         prop_gain_ff  <= '0;
         integ_gain_ff <= '0;
         deriv_gain_ff <= '0;
         time_step_ff  <= STEP_ONE;
         out_low_ff    <= {1'b1, {(GAIN_W-1){1'b0}}};
         out_high_ff   <= {1'b0, {(GAIN_W-1){1'b1}}};
      end else if (csr_wr) begin
         case (csr_idx)
            CSR_PROP_GAIN:  prop_gain_ff  <= signed'(csr_pwdata[GAIN_W-1:0]);
            CSR_INTEG_GAIN: integ_gain_ff <= signed'(csr_pwdata[GAIN_W-1:0]);
            CSR_DERIV_GAIN: deriv_gain_ff <= signed'(csr_pwdata[GAIN_W-1:0]);
            CSR_TIME_STEP:  time_step_ff  <= csr_pwdata[STEP_W-1:0];
            CSR_OUT_LOW:    out_low_ff    <= signed'(csr_pwdata[GAIN_W-1:0]);
            CSR_OUT_HIGH:   out_high_ff   <= signed'(csr_pwdata[GAIN_W-1:0]);
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      case (csr_idx)
         CSR_PROP_GAIN:  csr_prdata = CSR_DATA_W'(unsigned'(prop_gain_ff));
         CSR_INTEG_GAIN: csr_prdata = CSR_DATA_W'(unsigned'(integ_gain_ff));
         CSR_DERIV_GAIN: csr_prdata = CSR_DATA_W'(unsigned'(deriv_gain_ff));
         CSR_TIME_STEP:  csr_prdata = CSR_DATA_W'(time_step_ff);
         CSR_OUT_LOW:    csr_prdata = CSR_DATA_W'(unsigned'(out_low_ff));
         CSR_OUT_HIGH:   csr_prdata = CSR_DATA_W'(unsigned'(out_high_ff));
         default:        csr_prdata = '0;
      endcase
   end

   // Operand preparation.
   assign dt      = (time_step_ff == '0) ? STEP_W'(1) : time_step_ff;
   assign err_in  = ERR_W'(req_chan.target) - ERR_W'(req_chan.measured);
   assign err_abs = err_in[ERR_W-1] ? unsigned'(-err_in) : unsigned'(err_in);

   assign diff     = DIFF_W'(err_ff) - DIFF_W'(last_err_ff);
   assign diff_abs = diff[DIFF_W-1] ? unsigned'(-diff) : unsigned'(diff);
   assign div_num  = {diff_abs[DMAG_W-1:0], {(2*FRAC_BITS){1'b0}}};

   assign inc   = (mul_ff > INC_CAP) ? INC_CAP[INC_W-1:0] : mul_ff[INC_W-1:0];
   assign inc_x = signed'(SUMX_W'(inc));
   assign sum_x = err_ff[ERR_W-1] ? SUMX_W'(error_sum_ff) - inc_x
                                  : SUMX_W'(error_sum_ff) + inc_x;

   assign sum_abs = error_sum_ff[SUM_W-1] ? unsigned'(-error_sum_ff)
                                          : unsigned'(error_sum_ff);

   always_comb begin
      case (term_ff)
         TERM_P: begin
            gain_sel = prop_gain_ff;
            a_sel    = A_W'(err_mag_ff);
            a_neg    = err_ff[ERR_W-1];
         end
         TERM_I: begin
            gain_sel = integ_gain_ff;
            a_sel    = A_W'(sum_abs);
            a_neg    = error_sum_ff[SUM_W-1];
         end
         default: begin
            gain_sel = deriv_gain_ff;
            a_sel    = A_W'(quot);
            a_neg    = diff_neg_ff;
         end
      endcase
   end

   assign gain_abs = gain_sel[GAIN_W-1] ? unsigned'(-gain_sel) : unsigned'(gain_sel);
   assign a_ext    = (NCH*MUL_W)'(a_sel);

   assign shamt = (SH_W'(chunk_ff) << $clog2(MUL_W))
                + ((term_ff == TERM_P) ? SH_W'(FRAC_BITS) : SH_W'(0));
   assign addend = ACC_W'(mul_ff) << shamt;
   assign total  = signed'(acc_ff[ACC_W-1:FRAC_BITS]);

   assign last_chunk = (chunk_ff == CH_W'(NCH - 1));
   assign out_free   = ~rsp_valid_ff | rsp_chan.ready;

   // Sequencer.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:    if (req_chan.valid) state_in = ST_INT_OPS;
         ST_INT_OPS: state_in = ST_INT_MUL;
         ST_INT_MUL: state_in = ST_INT_ADD;
         ST_INT_ADD: state_in = ST_OPS;
         ST_OPS: begin
            if (!(term_ff == TERM_D && div_busy)) state_in = ST_MUL;
         end
         ST_MUL:     state_in = ST_ACC;
         ST_ACC: begin
            if (last_chunk && term_ff == TERM_D) state_in = ST_CLAMP;
            else state_in = ST_OPS;
         end
         ST_CLAMP:   state_in = ST_DONE;
         ST_DONE:    if (out_free) state_in = ST_IDLE;
         default:    state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      in_ready  = 1'b0;
      div_start = 1'b0;
      int_ops   = 1'b0;
      mul_en    = 1'b0;
      int_upd   = 1'b0;
      ops_en    = 1'b0;
      acc_en    = 1'b0;
      clamp_en  = 1'b0;
      out_load  = 1'b0;
      case (state_ff)
         ST_IDLE:    in_ready = 1'b1;
         ST_INT_OPS: begin
            div_start = 1'b1;
            int_ops   = 1'b1;
         end
         ST_INT_MUL: mul_en = 1'b1;
         ST_INT_ADD: int_upd = 1'b1;
         ST_OPS:     ops_en = ~(term_ff == TERM_D && div_busy);
         ST_MUL:     mul_en = 1'b1;
         ST_ACC:     acc_en = 1'b1;
         ST_CLAMP:   clamp_en = 1'b1;
         ST_DONE:    out_load = out_free;
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Controller state.
   always_ff @(posedge clock) begin
      if (reset) begin
         error_sum_ff <= '0;
         last_err_ff  <= '0;
      end else if (int_upd) begin
         last_err_ff <= err_ff;
         if (sum_x > SUMX_MAX) begin
            error_sum_ff <= SUMX_MAX[SUM_W-1:0];
         end else if (sum_x < SUMX_MIN) begin
            error_sum_ff <= SUMX_MIN[SUM_W-1:0];
         end else begin
            error_sum_ff <= sum_x[SUM_W-1:0];
         end
      end
   end

   // Datapath.
   always_ff @(posedge clock) begin
      if (in_ready && req_chan.valid) begin
         err_ff     <= err_in;
         err_mag_ff <= err_abs[SAMPLE_WIDTH-1:0];
      end
      if (int_ops) begin
         opa_ff      <= MUL_W'(err_mag_ff);
         opb_ff      <= MUL_W'(dt);
         diff_neg_ff <= diff[DIFF_W-1];
      end
      if (ops_en) begin
         opa_ff <= a_ext[chunk_ff*MUL_W +: MUL_W];
         opb_ff <= gain_abs;
         neg_ff <= a_neg ^ gain_sel[GAIN_W-1];
      end
      if (mul_en) begin
         mul_ff <= PROD_W'(opa_ff) * PROD_W'(opb_ff);
      end
      if (int_upd) begin
         term_ff  <= TERM_P;
         chunk_ff <= '0;
         acc_ff   <= '0;
      end
      if (acc_en) begin
         acc_ff <= neg_ff ? acc_ff - addend : acc_ff + addend;
         if (last_chunk) begin
            chunk_ff <= '0;
            case (term_ff)
               TERM_P:  term_ff <= TERM_I;
               default: term_ff <= TERM_D;
            endcase
         end else begin
            chunk_ff <= chunk_ff + CH_W'(1);
         end
      end
      if (clamp_en) begin
         over_ff   <= total > TOT_W'(out_high_ff);
         under_ff  <= total < TOT_W'(out_low_ff);
         tot_lo_ff <= total[DRIVE_W-1:0];
      end
      if (out_load) begin
         if (over_ff) begin
            drive_ff <= out_high_ff;
         end else if (under_ff) begin
            drive_ff <= out_low_ff;
         end else begin
            drive_ff <= signed'(tot_lo_ff);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   pidc_div #(
      .NUM_W (NUM_W),
      .DEN_W (STEP_W)
   ) u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (div_num),
      .den   (dt),
      .busy  (div_busy),
      .quot  (quot)
   );

   assign req_chan.ready = in_ready;
   assign rsp_chan.valid = rsp_valid_ff;
   assign rsp_chan.drive = drive_ff;

endmodule

// ===== hdl/pidc_div.sv =====
// ----------------------------------------------------------------------------
// PID controller divider
// Restoring unsigned divider that retires one quotient bit per cycle.
// ----------------------------------------------------------------------------
module pidc_div import pidc_pkg::*; #(
   parameter int NUM_W = 49,
   parameter int DEN_W = STEP_W
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [NUM_W-1:0] num,
   input  logic [DEN_W-1:0] den,
   output logic             busy,
   output logic [NUM_W-1:0] quot
);

   localparam int CNT_W   = $clog2(NUM_W);
   localparam int TRIAL_W = DEN_W + 2;

   logic             busy_ff;
   logic [CNT_W-1:0] cnt_ff;
   logic [DEN_W-1:0] rem_ff;
   logic [DEN_W-1:0] rem_in;
   logic [NUM_W-1:0] quot_ff;
   logic [TRIAL_W-1:0] shifted;
   logic [TRIAL_W-1:0] trial;
   logic               qbit;

   assign shifted = {1'b0, rem_ff, quot_ff[NUM_W-1]};
   assign trial   = shifted - TRIAL_W'(den);
   assign qbit    = ~trial[TRIAL_W-1];
   assign rem_in  = qbit ? trial[DEN_W-1:0] : shifted[DEN_W-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else if (start) begin
         busy_ff <= 1'b1;
         cnt_ff  <= '0;
      end else if (busy_ff) begin
         cnt_ff <= cnt_ff + CNT_W'(1);
         if (cnt_ff == CNT_W'(NUM_W - 1)) begin
            busy_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         rem_ff  <= '0;
         quot_ff <= num;
      end else if (busy_ff) begin
         rem_ff  <= rem_in;
         quot_ff <= {quot_ff[NUM_W-2:0], qbit};
      end
   end

   assign busy = busy_ff;
   assign quot = quot_ff;

endmodule

// ===== hdl/pidc_checker.sv =====
// ----------------------------------------------------------------------------
// PID controller checker
// Port-level assertions on transaction ordering and result hand-off.
// ----------------------------------------------------------------------------
module pidc_checker import pidc_pkg::*; (
   input logic               clock,
   input logic               reset,
   input logic               req_valid,
   input logic               req_ready,
   input logic               rsp_valid,
   input logic               rsp_ready,
   input logic [DRIVE_W-1:0] rsp_drive
);

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("Input ready stayed high after a sample transaction.");

   a_no_result_on_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !$rose(rsp_valid))
      else $error("A result appeared right after a sample transaction.");

   a_free_with_result: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> req_ready)
      else $error("A new result appeared while the controller was still busy.");

   a_result_held: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_drive)))
      else $error("A stalled result transaction changed or was dropped.");

endmodule

bind pid_controller_clamped pidc_checker u_pidc_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_chan.valid),
   .req_ready (req_chan.ready),
   .rsp_valid (rsp_chan.valid),
   .rsp_ready (rsp_chan.ready),
   .rsp_drive (rsp_chan.drive)
);

// ===== tb/sv/pid_controller_clamped_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Clamped PID controller testbench
// Sends sample transactions and checks every drive transaction against a
// bit-exact controller model kept in step with the registers. Register
// writes happen only while the controller is idle; defined ones are read back.
// A directed table covers the limits of the fields and the special cases, and
// random phases with random gains, steps, limits and traffic gaps follow.
// ----------------------------------------------------------------------------
module pid_controller_clamped_test;
   import pidc_pkg::*;

   localparam int FRAC          = FRAC_BITS_DEF;
   localparam int SW            = SAMPLE_WIDTH_DEF;
   localparam int RANDOM_PHASES = 13;
   localparam int PHASE_SAMPLES = 100;
   localparam int DRAIN_CYCLES  = 70;
   localparam int TIMEOUT_NS    = 20_000_000;

   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_A = 3'd6;
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_B = 3'd7;

   localparam longint SUM_HIGH = (longint'(1) <<< (SUM_W - 1)) - 1;
   localparam longint SUM_LOW  = -SUM_HIGH - 1;

   typedef enum bit {ROW_WRITE, ROW_SAMPLE} row_kind_type;

   typedef struct {
      row_kind_type              kind;
      logic [CSR_IDX_W-1:0]      idx;
      logic [CSR_DATA_W-1:0]     value;
      logic signed [SW-1:0]      tgt;
      logic signed [SW-1:0]      meas;
      bit                        pinned;
      logic signed [DRIVE_W-1:0] drive;
   } plan_row_type;

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  csr_psel;
   logic                  csr_penable;
   logic                  csr_pwrite;
   logic [CSR_ADDR_W-1:0] csr_paddr;
   logic [CSR_DATA_W-1:0] csr_pwdata;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   pidc_req_if req_bus ();
   pidc_rsp_if rsp_bus ();

   pid_controller_clamped dut (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_bus),
      .rsp_chan    (rsp_bus),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   logic signed [GAIN_W-1:0]  cfg_kp = '0;
   logic signed [GAIN_W-1:0]  cfg_ki = '0;
   logic signed [GAIN_W-1:0]  cfg_kd = '0;
   logic [STEP_W-1:0]         cfg_step = STEP_W'(1 << FRAC);
   logic signed [DRIVE_W-1:0] cfg_lo = 32'sh8000_0000;
   logic signed [DRIVE_W-1:0] cfg_hi = 32'sh7FFF_FFFF;
   longint                    integ_sum = 0;
   longint                    last_err_pred = 0;

   logic signed [DRIVE_W-1:0] expected_drives [$];
   int                        fault_count = 0;
   bit                        calm = 1'b0;
   logic                      pin_now;
   logic signed [DRIVE_W-1:0] pin_drive;

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   initial begin
      #(TIMEOUT_NS);
      $display("Regression FAIL");
      $finish;
   end

   task automatic flag_mismatch(input string what, input logic [31:0] want, input logic [31:0] got);
      fault_count++;
      if (fault_count <= 10) begin
         $display("%s mismatch: expected %h, got %h", what, want, got);
      end
   endtask

   function automatic logic signed [DRIVE_W-1:0] predict_drive(
      input logic signed [SW-1:0] tgt,
      input logic signed [SW-1:0] meas
   );
      longint                    err;
      longint                    diff;
      longint                    next_sum;
      longint unsigned           step_eff;
      longint unsigned           err_mag;
      longint unsigned           diff_mag;
      logic [127:0]              quot;
      logic signed [127:0]       deriv;
      logic signed [127:0]       err_w;
      logic signed [127:0]       sum_w;
      logic signed [127:0]       kp_w;
      logic signed [127:0]       ki_w;
      logic signed [127:0]       kd_w;
      logic signed [127:0]       lo_w;
      logic signed [127:0]       hi_w;
      logic signed [127:0]       total;
      logic signed [DRIVE_W-1:0] result;
      err = longint'(tgt) - longint'(meas);
      step_eff = (cfg_step == '0) ? 64'd1 : 64'(cfg_step);
      err_mag = (err < 0) ? -err : err;
      if (err < 0) begin
         next_sum = integ_sum - longint'(err_mag * step_eff);
      end else begin
         next_sum = integ_sum + longint'(err_mag * step_eff);
      end
      if (next_sum > SUM_HIGH) begin
         next_sum = SUM_HIGH;
      end else if (next_sum < SUM_LOW) begin
         next_sum = SUM_LOW;
      end
      integ_sum = next_sum;

      // The derivative divides the exact error step, scaled to Q.2F, by the step.
      diff = err - last_err_pred;
      diff_mag = (diff < 0) ? -diff : diff;
      quot = (128'(diff_mag) << (2 * FRAC)) / 128'(step_eff);
      deriv = (diff < 0) ? -$signed(quot) : $signed(quot);

      err_w = err;
      sum_w = integ_sum;
      kp_w = cfg_kp;
      ki_w = cfg_ki;
      kd_w = cfg_kd;
      lo_w = cfg_lo;
      hi_w = cfg_hi;
      total = ((err_w * kp_w) <<< FRAC) + sum_w * ki_w + deriv * kd_w;
      total = total >>> FRAC;
      if (total > hi_w) begin
         result = cfg_hi;
      end else if (total < lo_w) begin
         result = cfg_lo;
      end else begin
         result = total[DRIVE_W-1:0];
      end
      last_err_pred = err;
      return result;
   endfunction

   always @(posedge clock) begin
      logic signed [DRIVE_W-1:0] predicted;
      if (!reset && req_bus.valid && req_bus.ready) begin
         predicted = predict_drive(req_bus.target, req_bus.measured);
         expected_drives.push_back(pin_now ? pin_drive : predicted);
      end
   end

   always @(posedge clock) begin
      logic signed [DRIVE_W-1:0] want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (expected_drives.size() == 0) begin
            flag_mismatch("unexpected drive", 'x, rsp_bus.drive);
         end else begin
            want = expected_drives.pop_front();
            if (rsp_bus.drive !== want) begin
               flag_mismatch("drive", want, rsp_bus.drive);
            end
         end
      end
   end

   function automatic int unsigned pick_gap();
      int unsigned roll;
      roll = $urandom_range(0, 99);
      if (roll < 70) begin
         return $urandom_range(1, 3);
      end
      if (roll < 95) begin
         return $urandom_range(4, 20);
      end
      return $urandom_range(30, 150);
   endfunction

   initial begin
      rsp_bus.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (calm || $urandom_range(0, 3) != 0) begin
            rsp_bus.ready <= 1'b1;
         end else begin
            rsp_bus.ready <= 1'b0;
            repeat (pick_gap() - 1) @(negedge clock);
         end
      end
   end

   function automatic logic signed [SW-1:0] pick_extreme();
      case ($urandom_range(0, 3))
         0: return 16'sh8000;
         1: return 16'sh7FFF;
         2: return '0;
         default: return -16'sd1;
      endcase
   endfunction

   function automatic void pick_sample(output logic signed [SW-1:0] tgt,
                                       output logic signed [SW-1:0] meas);
      case ($urandom_range(0, 4))
         0, 1: begin
            tgt = 16'($urandom);
            meas = 16'($urandom);
         end
         2: begin
            tgt = pick_extreme();
            meas = pick_extreme();
         end
         3: begin
            tgt = 16'($urandom);
            meas = tgt + 16'($urandom_range(0, 64)) - 16'sd32;
         end
         default: begin
            tgt = 16'($urandom_range(0, 200)) - 16'sd100;
            meas = 16'($urandom_range(0, 200)) - 16'sd100;
         end
      endcase
   endfunction

   function automatic logic [31:0] pick_gain();
      logic [31:0] mag;
      mag = $urandom_range(0, 1 << 18);
      case ($urandom_range(0, 5))
         0: return 32'h8000_0000;
         1: return 32'h7FFF_FFFF;
         2: return '0;
         5: return $urandom;
         default: return $urandom_range(0, 1) ? mag : -mag;
      endcase
   endfunction

   function automatic logic [31:0] pick_step();
      logic [31:0] step;
      case ($urandom_range(0, 6))
         0: step = 32'd0;
         1: step = 32'd1;
         2: step = 32'h0001_0000;
         3: step = 32'h7FFF_FFFF;
         4, 5: step = $urandom_range(1, 1 << 20);
         default: step = $urandom;
      endcase
      step[31] = $urandom_range(0, 1);
      return step;
   endfunction

   function automatic void pick_limits(output logic [31:0] lo, output logic [31:0] hi);
      logic [31:0] span;
      case ($urandom_range(0, 3))
         0: begin
            lo = 32'h8000_0000;
            hi = 32'h7FFF_FFFF;
         end
         1: begin
            span = $urandom_range(0, 1 << 24);
            lo = -span;
            hi = span;
         end
         2: begin
            lo = $urandom;
            hi = $urandom;
         end
         default: begin
            lo = $urandom;
            hi = lo;
         end
      endcase
   endfunction

   // Every task below starts and ends on a falling edge.
   task automatic send_sample(input logic signed [SW-1:0] tgt, input logic signed [SW-1:0] meas,
                              input bit pin, input logic signed [DRIVE_W-1:0] pinned);
      int unsigned gap;
      gap = (calm || $urandom_range(0, 1)) ? 0 : pick_gap();
      if (gap != 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_bus.valid <= 1'b1;
      req_bus.target <= tgt;
      req_bus.measured <= meas;
      pin_now <= pin;
      pin_drive <= pinned;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic settle();
      req_bus.valid <= 1'b0;
      while (expected_drives.size() != 0) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic program_reg(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DATA_W-1:0] value);
      logic [CSR_DATA_W-1:0] want;
      bit                    known;
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= {idx, 2'b00};
      csr_pwdata <= value;
      @(negedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      known = 1'b1;
      case (idx)
         CSR_PROP_GAIN: begin
            cfg_kp = value;
            want = value;
         end
         CSR_INTEG_GAIN: begin
            cfg_ki = value;
            want = value;
         end
         CSR_DERIV_GAIN: begin
            cfg_kd = value;
            want = value;
         end
         CSR_TIME_STEP: begin
            cfg_step = value[STEP_W-1:0];
            want = {1'b0, value[STEP_W-1:0]};
         end
         CSR_OUT_LOW: begin
            cfg_lo = value;
            want = value;
         end
         CSR_OUT_HIGH: begin
            cfg_hi = value;
            want = value;
         end
         default: begin
            known = 1'b0;
            want = '0;
         end
      endcase
      @(negedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      @(negedge clock);
      if (known) begin
         csr_psel <= 1'b1;
         csr_pwrite <= 1'b0;
         @(negedge clock);
         csr_penable <= 1'b1;
         @(posedge clock);
         while (!csr_pready) @(posedge clock);
         if (csr_prdata !== want) begin
            flag_mismatch("register readback", want, csr_prdata);
         end
         @(negedge clock);
         csr_psel <= 1'b0;
         csr_penable <= 1'b0;
         @(negedge clock);
      end
   endtask

   function automatic plan_row_type reg_row(input logic [CSR_IDX_W-1:0] idx,
                                            input logic [CSR_DATA_W-1:0] value);
      plan_row_type row;
      row = '{ROW_WRITE, idx, value, '0, '0, 1'b0, '0};
      return row;
   endfunction

   function automatic plan_row_type sample_row(input int tgt, input int meas);
      plan_row_type row;
      row = '{ROW_SAMPLE, '0, '0, SW'(tgt), SW'(meas), 1'b0, '0};
      return row;
   endfunction

   function automatic plan_row_type pinned_row(input int tgt, input int meas,
                                               input logic signed [DRIVE_W-1:0] drive);
      plan_row_type row;
      row = '{ROW_SAMPLE, '0, '0, SW'(tgt), SW'(meas), 1'b1, drive};
      return row;
   endfunction

   initial begin
      plan_row_type         plan [$];
      logic signed [SW-1:0] tgt;
      logic signed [SW-1:0] meas;
      logic [31:0]          lo_val;
      logic [31:0]          hi_val;
      reset = 1'b1;
      req_bus.valid = 1'b0;
      req_bus.target = '0;
      req_bus.measured = '0;
      pin_now = 1'b0;
      pin_drive = '0;
      csr_psel = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite = 1'b0;
      csr_paddr = '0;
      csr_pwdata = '0;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // All gains are zero after reset, then a unit proportional gain shows the
      // clamp at the extremes, at narrow limits and at crossed limits. A zero
      // step stands for the smallest step, and a tiny integral gain with the
      // largest step drives the integral into saturation both ways.
      plan = '{
         pinned_row(32767, -32768, 32'sd0),
         pinned_row(-32768, 32767, 32'sd0),
         pinned_row(0, 0, 32'sd0),
         reg_row(CSR_PROP_GAIN, 32'h0001_0000),
         pinned_row(32767, -32768, 32'sh7FFF_FFFF),
         pinned_row(-32768, 32767, 32'sh8000_0000),
         pinned_row(5, 3, 32'sd131072),
         reg_row(CSR_OUT_LOW, 32'hFF9C_0000),
         reg_row(CSR_OUT_HIGH, 32'h0064_0000),
         pinned_row(1000, 0, 32'sh0064_0000),
         pinned_row(0, 1000, 32'shFF9C_0000),
         pinned_row(50, 0, 32'sh0032_0000),
         reg_row(CSR_OUT_LOW, 32'd1000),
         reg_row(CSR_OUT_HIGH, 32'hFFFF_FC18),
         pinned_row(0, 0, -32'sd1000),
         pinned_row(1, 0, -32'sd1000),
         pinned_row(0, 1, 32'sd1000),
         reg_row(CSR_OUT_LOW, 32'h8000_0000),
         reg_row(CSR_OUT_HIGH, 32'h7FFF_FFFF),
         reg_row(CSR_PROP_GAIN, 32'd0),
         reg_row(CSR_DERIV_GAIN, 32'h0001_0000),
         reg_row(CSR_TIME_STEP, 32'd0),
         sample_row(100, 90),
         sample_row(-32768, 32767),
         sample_row(32767, -32768),
         sample_row(0, 0),
         reg_row(CSR_DERIV_GAIN, 32'd0),
         reg_row(CSR_INTEG_GAIN, 32'd1),
         reg_row(CSR_TIME_STEP, 32'hFFFF_FFFF),
         sample_row(32767, -32768),
         sample_row(32767, -32768),
         sample_row(-32768, 32767),
         sample_row(-32768, 32767),
         sample_row(-32768, 32767),
         reg_row(CSR_INTEG_GAIN, 32'h8000_0000),
         sample_row(0, 0),
         reg_row(CSR_SPARE_A, 32'h1234_5678),
         reg_row(CSR_SPARE_B, 32'hFFFF_FFFF),
         sample_row(-1, 1),
         sample_row(7, -7)
      };
      foreach (plan[n]) begin
         if (plan[n].kind == ROW_WRITE) begin
            settle();
            program_reg(plan[n].idx, plan[n].value);
         end else begin
            send_sample(plan[n].tgt, plan[n].meas, plan[n].pinned, plan[n].drive);
         end
      end

      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         settle();
         calm = ($urandom_range(0, 3) == 0);
         if ($urandom_range(0, 1)) begin
            program_reg(CSR_PROP_GAIN, pick_gain());
         end
         if ($urandom_range(0, 1)) begin
            program_reg(CSR_INTEG_GAIN, pick_gain());
         end
         if ($urandom_range(0, 1)) begin
            program_reg(CSR_DERIV_GAIN, pick_gain());
         end
         if ($urandom_range(0, 1)) begin
            program_reg(CSR_TIME_STEP, pick_step());
         end
         if ($urandom_range(0, 1)) begin
            pick_limits(lo_val, hi_val);
            program_reg(CSR_OUT_LOW, lo_val);
            program_reg(CSR_OUT_HIGH, hi_val);
         end
         if ($urandom_range(0, 7) == 0) begin
            program_reg($urandom_range(0, 1) ? CSR_SPARE_A : CSR_SPARE_B, $urandom);
         end
         repeat (PHASE_SAMPLES) begin
            pick_sample(tgt, meas);
            send_sample(tgt, meas, 1'b0, '0);
         end
      end

      settle();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fault_count == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule
